[design/lwss_pkg.sv]
// Package for the word span scanner: field widths, scan phases and character classes.
`timescale 1ns / 1ps
`default_nettype none

package lwss_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned START_W = 12;
  localparam int unsigned END_W   = 13;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;
  localparam logic [COUNT_W-1:0] WORD_LIMIT_RESET = 11'd1024;

  localparam logic [CP_W-1:0] CP_UNDERSCORE = 21'h5f;
  localparam logic [CP_W-1:0] CP_PLUS       = 21'h2b;
  localparam logic [CP_W-1:0] CP_HASH       = 21'h23;
  localparam logic [CP_W-1:0] CP_APOSTROPHE = 21'h27;
  localparam logic [CP_W-1:0] CP_HYPHEN     = 21'h2d;
  localparam logic [CP_W-1:0] CP_DOT        = 21'h2e;
  localparam logic [CP_W-1:0] CP_RSQUOTE    = 21'h2019;
  localparam logic [CP_W-1:0] CP_LATIN_LO   = 21'h00c0;
  localparam logic [CP_W-1:0] CP_LATIN_HI   = 21'h024f;

  typedef enum logic [3:0] {
    PH_OUT  = 4'b0001,
    PH_DOT  = 4'b0010,
    PH_IN   = 4'b0100,
    PH_CONN = 4'b1000
  } phase_t;

  function automatic logic is_word_char(input logic [CP_W-1:0] c);
    return (c >= 21'h61 && c <= 21'h7a) || (c >= 21'h41 && c <= 21'h5a) ||
           (c >= 21'h30 && c <= 21'h39) || (c == CP_UNDERSCORE) ||
           (c >= CP_LATIN_LO && c <= CP_LATIN_HI);
  endfunction

  function automatic logic is_connector(input logic [CP_W-1:0] c);
    return (c == CP_APOSTROPHE) || (c == CP_HYPHEN) || (c == CP_DOT) ||
           (c == CP_RSQUOTE);
  endfunction

endpackage

`default_nettype wire

[design/lexical_word_span_scanner.sv]
// A word enters the input register, and its result enters the output register as it leaves.
// Throughput: one word per cycle; a word with a result waits while the output register holds
// an untaken result, one without never does; scan state updates once per word as it leaves.
// Reset (rst_n low, synchronous): scan state and span count clear, the word limit becomes
// 1024, both pipeline registers empty. The last word of a message also clears the scan state.
`timescale 1ns / 1ps
`default_nettype none

module lexical_word_span_scanner #(
  parameter int MAX_BYTES = 4096,
  parameter int MAX_SPANS = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [lwss_pkg::COUNT_W-1:0]      cfg_wdata,   // word limit
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [lwss_pkg::IN_DATA_W-1:0]    in_tdata,    // code_point, byte_len
  input  wire                               in_tlast,    // last
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [lwss_pkg::OUT_DATA_W-1:0]   out_tdata,   // span_start, span_end,
                                                         // span_index, words_found, pad
  output logic                              out_tuser,   // has_span
  output logic                              out_tlast    // is_last
);
  import lwss_pkg::*;

  localparam int OFF_W = $clog2(MAX_BYTES + 1);

  logic [COUNT_W-1:0] word_limit_r;

  // Input register
  logic              s1_valid_r;
  logic [CP_W-1:0]   s1_cp_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_last_r;

  // Scan state
  phase_t             phase_r, phase_nxt;
  logic [OFF_W-1:0]   byte_offset_r, byte_offset_nxt;
  logic [OFF_W-1:0]   word_start_r, word_start_nxt;
  logic [OFF_W-1:0]   conn_off_r, conn_off_nxt;
  logic [COUNT_W-1:0] span_count_r, span_count_nxt;

  // Output register
  logic               out_valid_r;
  logic               has_span_r, has_span_nxt;
  logic [START_W-1:0] span_start_r, span_start_nxt;
  logic [END_W-1:0]   span_end_r, span_end_nxt;
  logic [INDEX_W-1:0] span_index_r, span_index_nxt;
  logic [COUNT_W-1:0] words_found_r;
  logic               is_last_r;

  logic               wc, conn, dot, ext;
  logic [OFF_W:0]     sum;
  logic [OFF_W-1:0]   here, next_off;
  logic               done;
  logic [OFF_W-1:0]   es, ee;
  logic               emit, produce, adv;
  phase_t             fo_phase;
  logic               fo_start;

  assign here = byte_offset_r;
  assign sum  = {1'b0, here} + (OFF_W+1)'(s1_len_r);
  assign next_off = (sum > (OFF_W+1)'(MAX_BYTES)) ? OFF_W'(MAX_BYTES) : sum[OFF_W-1:0];

  assign wc   = is_word_char(s1_cp_r);
  assign conn = is_connector(s1_cp_r);
  assign dot  = (s1_cp_r == CP_DOT);
  assign ext  = wc || (s1_cp_r == CP_PLUS) || (s1_cp_r == CP_HASH);

  // A character seen from outside a word: a dot may open a word, a word character does.
  always_comb begin
    fo_start = dot || wc;
    if (dot) begin
      fo_phase = PH_DOT;
    end else if (wc) begin
      fo_phase = PH_IN;
    end else begin
      fo_phase = PH_OUT;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    word_start_nxt = word_start_r;
    conn_off_nxt   = conn_off_r;
    done           = 1'b0;
    es             = word_start_r;
    ee             = here;
    unique case (phase_r)
      PH_OUT: begin
        phase_nxt = fo_phase;
        if (fo_start) word_start_nxt = here;
      end
      PH_DOT: begin
        if (wc) begin
          phase_nxt = PH_IN;
        end else begin
          phase_nxt = fo_phase;
          if (fo_start) word_start_nxt = here;
        end
      end
      PH_IN: begin
        if (ext) begin
          phase_nxt = PH_IN;
        end else if (conn) begin
          conn_off_nxt = here;
          phase_nxt    = PH_CONN;
        end else begin
          done      = 1'b1;
          ee        = here;
          phase_nxt = PH_OUT;
        end
      end
      PH_CONN: begin
        if (wc) begin
          phase_nxt = PH_IN;
        end else begin
          // The word ends before the connector, which is then dropped.
          done      = 1'b1;
          ee        = conn_off_r;
          phase_nxt = fo_phase;
          if (fo_start) word_start_nxt = here;
        end
      end
      default: begin
        phase_nxt = PH_OUT;
      end
    endcase

    // The last word flushes an open span; a pending connector stays outside it.
    if (s1_last_r) begin
      if (phase_nxt == PH_IN) begin
        done = 1'b1;
        es   = word_start_nxt;
        ee   = next_off;
      end else if (phase_nxt == PH_CONN) begin
        done = 1'b1;
        es   = word_start_nxt;
        ee   = conn_off_nxt;
      end
    end
  end

  assign emit = done && (span_count_r < word_limit_r) &&
                (32'(span_count_r) < MAX_SPANS);
  assign produce = emit || s1_last_r;
  assign adv = s1_valid_r && (!produce || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign span_count_nxt  = span_count_r + COUNT_W'(emit);
  assign byte_offset_nxt = next_off;
  assign has_span_nxt    = emit;
  assign span_start_nxt  = emit ? START_W'(es) : '0;
  assign span_end_nxt    = emit ? END_W'(ee) : '0;
  assign span_index_nxt  = emit ? INDEX_W'(span_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_limit_r <= WORD_LIMIT_RESET;
    end else if (cfg_we) begin
      word_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cp_r   <= in_tdata[CP_W-1:0];
      s1_len_r  <= in_tdata[CP_W +: LEN_W];
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OUT;
      byte_offset_r <= '0;
      word_start_r  <= '0;
      conn_off_r    <= '0;
      span_count_r  <= '0;
    end else if (adv) begin
      if (s1_last_r) begin
        phase_r       <= PH_OUT;
        byte_offset_r <= '0;
        word_start_r  <= '0;
        conn_off_r    <= '0;
        span_count_r  <= '0;
      end else begin
        phase_r       <= phase_nxt;
        byte_offset_r <= byte_offset_nxt;
        word_start_r  <= word_start_nxt;
        conn_off_r    <= conn_off_nxt;
        span_count_r  <= span_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      has_span_r    <= has_span_nxt;
      span_start_r  <= span_start_nxt;
      span_end_r    <= span_end_nxt;
      span_index_r  <= span_index_nxt;
      words_found_r <= span_count_nxt;
      is_last_r     <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = has_span_r;
  assign out_tlast  = is_last_r;
  assign out_tdata  = {2'b00, words_found_r, span_index_r, span_end_r, span_start_r};

  // A result without a span only comes from the last word of a message.
  a_nospan_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("span-less result without last flag");

  // A reported span always counts itself.
  a_span_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> words_found_r != '0)
    else $error("span reported with zero words_found");

  // The last word of a message leaves the scan state cleared.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> byte_offset_r == '0 && span_count_r == '0 && phase_r == PH_OUT)
    else $error("scan state not cleared after last word");

  // The byte offset never passes its saturation point.
  a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(byte_offset_r) <= MAX_BYTES)
    else $error("byte offset beyond saturation");

endmodule

`default_nettype wire
